// File: sv/ped_pkg.sv
// Shared types and constants for the pairwise distance block.
`default_nettype none

package ped_pkg;

  localparam int IDX_W       = 6;    // row and column index width
  localparam int CNT_W       = 7;    // stored point count width
  localparam int DIST_W      = 17;   // distance width, unsigned Q17.0
  localparam int RAD_W       = 2 * DIST_W;  // radicand width after saturation
  localparam int REM_W       = DIST_W + 2;  // partial remainder width in the root
  localparam int DIFF_W      = DIST_W + 1;  // clamped coordinate difference width
  localparam int SQ_W        = 2 * DIST_W + 1;  // square of a clamped difference
  localparam int ROOT_STAGES = DIST_W;  // one result bit per stage
  localparam int OUT_TDATA_W = 32;

  // A difference of 2^17 or more already saturates the distance.
  localparam logic [DIFF_W-1:0] DIFF_SAT = DIFF_W'(1) << DIST_W;

  typedef enum logic {
    ST_IDLE,
    ST_ISSUE
  } ped_state_t;

  // Per-result tag that travels alongside the arithmetic.
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
    logic             ovf;
    logic             zero;  // force distance to 0 (diagonal, dropped point)
  } ped_meta_t;

endpackage

`default_nettype wire

// File: sv/ped_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a tag.
`default_nettype none

module ped_isqrt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_vld,
  input  wire logic [ped_pkg::RAD_W-1:0]  in_rad,
  input  wire ped_pkg::ped_meta_t         in_meta,
  output logic                            out_vld,
  output logic [ped_pkg::DIST_W-1:0]      out_root,
  output ped_pkg::ped_meta_t              out_meta
);
  import ped_pkg::*;

  logic                vld_r  [ROOT_STAGES];
  logic [RAD_W-1:0]    rad_r  [ROOT_STAGES];
  logic [REM_W-1:0]    rem_r  [ROOT_STAGES];
  logic [DIST_W-1:0]   root_r [ROOT_STAGES];
  ped_meta_t           meta_r [ROOT_STAGES];

  for (genvar j = 0; j < ROOT_STAGES; j++) begin : g_stage
    logic              vld_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [DIST_W-1:0] root_in;
    ped_meta_t         meta_in;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              take;

    if (j == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rad_in  = in_rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign meta_in = in_meta;
    end else begin : g_next
      assign vld_in  = vld_r[j-1];
      assign rad_in  = rad_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign meta_in = meta_r[j-1];
    end

    // bring down the next two radicand bits and try (2*root)*2 + 1
    assign rem_sh = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial  = (REM_W+2)'({root_in, 2'b01});
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[j]  <= {rad_in[RAD_W-3:0], 2'b00};
        rem_r[j]  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        root_r[j] <= {root_in[DIST_W-2:0], take};
        meta_r[j] <= meta_in;
      end
    end
  end

  assign out_vld  = vld_r[ROOT_STAGES-1];
  assign out_root = root_r[ROOT_STAGES-1];
  assign out_meta = meta_r[ROOT_STAGES-1];

endmodule

`default_nettype wire

// File: sv/pairwise_euclidean_distance.sv
// Top level: point store and lower-triangle distance row generator.
//
//  channel | direction | tdata (low bit up)                      | tuser     | tlast
//  in_     | sink      | x_coord, y_coord, zero pad              | start_set | -
//  out_    | source    | row_index, col_index, distance, pad     | overflow  | last_of_row
//
// Each point is accepted and stored, then takes one memory read per earlier
// point and one slot for the diagonal entry.
// Each distance goes through a 21-stage path (read, diff, square, sum, 17 root
// stages) plus the output register; a stalled output freezes the whole path.
// A dropped point (store full) gets no reads. Reset clears the point count.
`default_nettype none

module pairwise_euclidean_distance #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  // x_coord, y_coord, zero pad
  input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]      in_tdata,
  // start_set
  input  wire logic                                   in_tuser,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  // row_index, col_index, distance, zero pad
  output logic [ped_pkg::OUT_TDATA_W-1:0]             out_tdata,
  // overflow
  output logic                                        out_tuser,
  output logic                                        out_tlast
);
  import ped_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int EW = (COORD_BITS + 1 > DIFF_W) ? COORD_BITS + 1 : DIFF_W;

  // control
  ped_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [IDX_W-1:0]     k_r, k_nxt;
  logic [IDX_W-1:0]     row_r, row_nxt;
  logic [COORD_BITS-1:0] cur_x_r, cur_y_r;
  logic                 adv;
  logic                 accept;
  logic [CNT_W-1:0]     eff_cnt;
  logic                 full;
  logic                 issue_vld;
  logic                 rd_en;
  ped_meta_t            issue_meta;

  // point store
  logic [2*COORD_BITS-1:0] mem [MAX_POINTS];
  logic [2*COORD_BITS-1:0] rd_r;

  // datapath
  logic                 s0_vld_r, s1_vld_r, s2_vld_r, s3_vld_r;
  ped_meta_t            s0_meta_r, s1_meta_r, s2_meta_r, s3_meta_r;
  logic [DIFF_W-1:0]    dx_nxt, dy_nxt, dx_r, dy_r;
  logic [SQ_W-1:0]      sqx_r, sqy_r;
  logic [SQ_W:0]        sum;
  logic [RAD_W-1:0]     rad_r;
  logic                 rt_vld;
  logic [DIST_W-1:0]    rt_root;
  ped_meta_t            rt_meta;

  // output register
  logic                 out_vld_r;
  logic [IDX_W-1:0]     out_row_r, out_col_r;
  logic [DIST_W-1:0]    out_dist_r;
  logic                 out_last_r, out_ovf_r;

  function automatic logic [DIFF_W-1:0] abs_clamp(input logic [COORD_BITS-1:0] a,
                                                   input logic [COORD_BITS-1:0] b);
    logic signed [COORD_BITS:0] d;
    logic [COORD_BITS:0]        m;
    logic [EW-1:0]              e;
    d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    m = d[COORD_BITS] ? $unsigned(-d) : $unsigned(d);
    e = EW'(m);
    return (e > EW'(DIFF_SAT)) ? DIFF_SAT : e[DIFF_W-1:0];
  endfunction

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && adv;
  assign accept    = in_tvalid && in_tready;
  assign eff_cnt   = in_tuser ? '0 : cnt_r;
  assign full      = (eff_cnt >= CNT_W'(MAX_POINTS));

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && !full) state_nxt = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (adv && (k_r == row_r)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    issue_vld  = 1'b0;
    rd_en      = 1'b0;
    issue_meta = '0;
    case (state_r)
      ST_IDLE: begin
        // dropped point: single flagged result
        issue_vld       = accept && full;
        issue_meta.last = 1'b1;
        issue_meta.ovf  = 1'b1;
        issue_meta.zero = 1'b1;
      end
      ST_ISSUE: begin
        issue_vld      = 1'b1;
        issue_meta.row = row_r;
        issue_meta.col = k_r;
        if (k_r == row_r) begin
          issue_meta.last = 1'b1;
          issue_meta.zero = 1'b1;
        end else begin
          rd_en = 1'b1;
        end
      end
      default: begin
        issue_vld = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    row_nxt = row_r;
    k_nxt   = k_r;
    if (accept) begin
      cnt_nxt = full ? eff_cnt : CNT_W'(eff_cnt + 1'b1);
      row_nxt = eff_cnt[IDX_W-1:0];
      k_nxt   = '0;
    end else if (rd_en && adv) begin
      k_nxt = k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      row_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      row_r   <= row_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x_r <= in_tdata[COORD_BITS-1:0];
      cur_y_r <= in_tdata[2*COORD_BITS-1:COORD_BITS];
    end
  end

  // ---------------- point store ----------------
  always_ff @(posedge clk) begin
    if (accept && !full) begin
      mem[eff_cnt[AW-1:0]] <= in_tdata[2*COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && rd_en) begin
      rd_r <= mem[k_r[AW-1:0]];
    end
  end

  // ---------------- distance path ----------------
  assign dx_nxt = abs_clamp(cur_x_r, rd_r[COORD_BITS-1:0]);
  assign dy_nxt = abs_clamp(cur_y_r, rd_r[2*COORD_BITS-1:COORD_BITS]);
  assign sum    = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= issue_vld;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_meta_r <= issue_meta;
      s1_meta_r <= s0_meta_r;
      s2_meta_r <= s1_meta_r;
      s3_meta_r <= s2_meta_r;
      dx_r      <= dx_nxt;
      dy_r      <= dy_nxt;
      sqx_r     <= SQ_W'(dx_r) * SQ_W'(dx_r);
      sqy_r     <= SQ_W'(dy_r) * SQ_W'(dy_r);
      // anything at or past 2^34 roots to the saturated distance anyway
      rad_r     <= (sum[SQ_W:RAD_W] != '0) ? '1 : sum[RAD_W-1:0];
    end
  end

  ped_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (s3_vld_r),
    .in_rad   (rad_r),
    .in_meta  (s3_meta_r),
    .out_vld  (rt_vld),
    .out_root (rt_root),
    .out_meta (rt_meta)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= rt_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_row_r  <= rt_meta.row;
      out_col_r  <= rt_meta.col;
      out_dist_r <= rt_meta.zero ? '0 : rt_root;
      out_last_r <= rt_meta.last;
      out_ovf_r  <= rt_meta.ovf;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TDATA_W'({out_dist_r, out_col_r, out_row_r});
  assign out_tuser  = out_ovf_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POINTS))
    else $error("point count above capacity");

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ISSUE) |-> (k_r <= row_r))
    else $error("column index ran past the row");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !full) |=> (cnt_r == CNT_W'($past(eff_cnt) + 1'b1)))
    else $error("stored point not counted");

  a_ovf_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ovf_r) |-> (out_last_r && out_row_r == '0 && out_col_r == '0
                                  && out_dist_r == '0))
    else $error("overflow request malformed");

  a_diag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_last_r && !out_ovf_r) |-> (out_row_r == out_col_r
                                                 && out_dist_r == '0))
    else $error("row does not close on its diagonal");
`endif

endmodule

`default_nettype wire
